@@ src/bofh_pkg.sv @@
// Shared constants and types for the brightest-of-four direction picker.
package bofh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LANES     = 4;
  localparam int DIR_W     = 2;
  localparam int LEVEL_W   = 12;
  localparam int GAIN_W    = 16;
  localparam int COUNTS_W  = 12;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_EVAL   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_COUNTS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_FRACTION = 2'd2;

  // choice state handed to the merge stage
  typedef struct packed {
    logic [DIR_W-1:0] chosen;
    logic             choice_made;
  } choice_t;

  // one result item
  typedef struct packed {
    logic [DIR_W-1:0]   brightest;
    logic [LEVEL_W-1:0] brightest_level;
    logic               is_seeded;
  } result_t;

endpackage

@@ src/bofh_lane.sv @@
// One smoothing lane: seed or exponential moving average update.
module bofh_lane import bofh_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic [SAMPLE_BITS+FRAC_BITS-1:0] avg,
  input  logic [SAMPLE_BITS-1:0]           sample,
  input  logic [GAIN_W-1:0]                gain,
  input  logic                             seeded,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0] avg_next
);

  localparam int AVG_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int DIFF_W = AVG_W + 1;
  localparam int PROD_W = DIFF_W + GAIN_W + 1;
  localparam int STEP_W = PROD_W - FRAC_BITS;

  logic [AVG_W-1:0]         target;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [STEP_W-1:0] step;
  logic signed [STEP_W-1:0] sum;

  assign target = {sample, {FRAC_BITS{1'b0}}};
  assign diff   = $signed({1'b0, target}) - $signed({1'b0, avg});
  assign prod   = PROD_W'(diff) * PROD_W'($signed({1'b0, gain}));
  // arithmetic shift floors toward minus infinity
  assign step   = STEP_W'(prod >>> FRAC_BITS);
  assign sum    = $signed(STEP_W'({1'b0, avg})) + step;

  assign avg_next = seeded ? sum[AVG_W-1:0] : target;

endmodule

@@ src/bofh_merge.sv @@
// Merge stage: argmax over the lanes and the hysteresis switch decision.
module bofh_merge import bofh_pkg::*; #(
  parameter int AVG_W = 28
) (
  input  logic [LANES-1:0][AVG_W-1:0] avgs,
  input  choice_t                     choice,
  input  logic [COUNTS_W-1:0]         counts,
  input  logic [GAIN_W-1:0]           fraction,
  output logic [DIR_W-1:0]            chosen_next
);

  localparam int ABS_W = COUNTS_W + FRAC_BITS;
  localparam int CMP_W = (AVG_W > ABS_W) ? AVG_W : ABS_W;
  localparam int REL_W = AVG_W + GAIN_W;

  logic [DIR_W-1:0] best;
  logic [AVG_W-1:0] best_val;
  logic [AVG_W-1:0] cur;
  logic [CMP_W-1:0] delta;
  logic [CMP_W-1:0] abs_t;
  logic [REL_W-1:0] rel_prod;
  logic [CMP_W-1:0] rel_t;
  logic [CMP_W-1:0] thresh;

  // strict compare keeps the lowest index on a tie
  always_comb begin
    best     = '0;
    best_val = avgs[0];
    for (int i = 1; i < LANES; i++) begin
      if (avgs[i] > best_val) begin
        best_val = avgs[i];
        best     = DIR_W'(i);
      end
    end
  end

  assign cur      = avgs[choice.chosen];
  assign delta    = CMP_W'(best_val - cur);
  assign abs_t    = CMP_W'({counts, {FRAC_BITS{1'b0}}});
  assign rel_prod = REL_W'(best_val) * REL_W'(fraction);
  assign rel_t    = CMP_W'(rel_prod >> FRAC_BITS);
  assign thresh   = (abs_t > rel_t) ? abs_t : rel_t;

  always_comb begin
    if (!choice.choice_made) begin
      chosen_next = best;
    end else if (delta > thresh) begin
      chosen_next = best;
    end else begin
      chosen_next = choice.chosen;
    end
  end

endmodule

@@ src/brightest_of_four_with_hysteresis.sv @@
// Top level: four smoothing lanes, argmax merge, skid-buffered result stream.
// Each result goes into the output register, or the skid entry when the output stalls.
// Throughput: one item per cycle while the skid entry is empty; each item is finished
//   when taken, by the lane multiply (sample items) or merge compare (evaluate).
// A two-deep output buffer keeps s_tready high while one result waits.
// Reset (rst, synchronous): averages zero, no choice, not seeded, defaults
//   9830 / 60 / 3277 in the configuration registers, both stream sides empty.
module brightest_of_four_with_hysteresis import bofh_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  // slave side
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,  // level_north, level_east, level_south, level_west
  input  logic                 s_tuser,  // kind
  // master side
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,  // brightest[1:0], brightest_level[13:2], zero pad
  output logic                 m_tuser,  // is_seeded
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AVG_W = SAMPLE_BITS + FRAC_BITS;

  // configuration registers
  logic [GAIN_W-1:0]   smoothing_gain;
  logic [COUNTS_W-1:0] hysteresis_counts;
  logic [GAIN_W-1:0]   hysteresis_fraction;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_gain      <= GAIN_W'(9830);
      hysteresis_counts   <= COUNTS_W'(60);
      hysteresis_fraction <= GAIN_W'(3277);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SMOOTHING_GAIN:      smoothing_gain      <= cfg_data;
        REG_HYSTERESIS_COUNTS:   hysteresis_counts   <= cfg_data[COUNTS_W-1:0];
        REG_HYSTERESIS_FRACTION: hysteresis_fraction <= cfg_data;
        default: ;
      endcase
    end
  end

  // block state
  logic [LANES-1:0][AVG_W-1:0] smoothed_levels;
  logic [LANES-1:0][AVG_W-1:0] smoothed_levels_next;
  logic [DIR_W-1:0]            chosen_direction;
  logic [DIR_W-1:0]            chosen_direction_next;
  logic                        choice_made;
  logic                        choice_made_next;
  logic                        seeded_flag;

  logic    in_xfer;
  logic    is_eval;
  choice_t choice;
  logic [DIR_W-1:0] merge_dir;
  result_t result;

  assign in_xfer = s_tvalid && s_tready;
  assign is_eval = (s_tuser == KIND_EVAL);

  // one lane per direction; readings are 12-bit fields cut to SAMPLE_BITS
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bofh_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane (
      .avg      (smoothed_levels[g]),
      .sample   (SAMPLE_BITS'(s_tdata[g*LEVEL_W +: LEVEL_W])),
      .gain     (smoothing_gain),
      .seeded   (seeded_flag),
      .avg_next (smoothed_levels_next[g])
    );
  end

  assign choice.chosen      = chosen_direction;
  assign choice.choice_made = choice_made;

  bofh_merge #(.AVG_W(AVG_W)) u_merge (
    .avgs        (smoothed_levels),
    .choice      (choice),
    .counts      (hysteresis_counts),
    .fraction    (hysteresis_fraction),
    .chosen_next (merge_dir)
  );

  // choice only moves on an evaluate once seeded
  always_comb begin
    chosen_direction_next = chosen_direction;
    choice_made_next      = choice_made;
    if (is_eval && seeded_flag) begin
      chosen_direction_next = merge_dir;
      choice_made_next      = 1'b1;
    end
  end

  // result for the item being taken
  always_comb begin
    if (!is_eval) begin
      result.brightest       = chosen_direction;
      result.brightest_level =
        LEVEL_W'(smoothed_levels_next[chosen_direction][AVG_W-1:FRAC_BITS]);
      result.is_seeded       = 1'b1;
    end else if (!seeded_flag) begin
      result = '0;
    end else begin
      result.brightest       = chosen_direction_next;
      result.brightest_level =
        LEVEL_W'(smoothed_levels[chosen_direction_next][AVG_W-1:FRAC_BITS]);
      result.is_seeded       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_levels  <= '0;
      chosen_direction <= '0;
      choice_made      <= 1'b0;
      seeded_flag      <= 1'b0;
    end else if (in_xfer) begin
      if (!is_eval) begin
        smoothed_levels <= smoothed_levels_next;
        seeded_flag     <= 1'b1;
      end
      chosen_direction <= chosen_direction_next;
      choice_made      <= choice_made_next;
    end
  end

  // output register plus skid entry
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;

  assign s_tready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_xfer) begin
        out_data <= result;
      end
    end else if (in_xfer) begin
      skid_data <= result;
    end
  end

  assign m_tdata = {2'b00, out_data.brightest_level, out_data.brightest};
  assign m_tuser = out_data.is_seeded;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid entry held with empty output register");

  a_sample_seeds: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && !is_eval) |=> seeded_flag)
    else $error("sample transfer did not seed averages");

  a_eval_chooses: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && is_eval && seeded_flag) |=> choice_made)
    else $error("seeded evaluate did not adopt a choice");

  a_choice_after_seed: assert property (@(posedge clk) disable iff (rst)
    choice_made |-> seeded_flag)
    else $error("choice made before seeding");

endmodule

@@ verif/brightest_of_four_with_hysteresis_test.sv @@
// Self-checking bench for the brightest-of-four smoothed direction picker.
module brightest_of_four_with_hysteresis_test;
  import bofh_pkg::*;

  localparam int SAMPLE_W     = 12;
  localparam int AVG_W        = SAMPLE_W + FRAC_BITS;
  localparam int IDLE_PCT     = 21;   // chance in 100 that a side idles
  localparam int PHASE_ITEMS  = 244;  // eight random phases, about 1950 items
  localparam int DRAIN_GUARD  = 20000;
  localparam int MAX_PRINTS   = 40;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [47:0]          s_tdata;   // level_north, level_east, level_south, level_west
  logic                 s_tuser;   // kind
  logic                 m_tvalid;
  logic                 m_tready;
  logic [15:0]          m_tdata;   // brightest[1:0], brightest_level[13:2], zero pad
  logic                 m_tuser;   // is_seeded
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  brightest_of_four_with_hysteresis i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block: smoothed levels (12.16), held choice, register copies.
  logic [AVG_W-1:0]    avg_level [LANES];
  logic [DIR_W-1:0]    held_dir;
  logic                dir_held;
  logic                levels_seeded;
  logic [GAIN_W-1:0]   gain_q16;
  logic [COUNTS_W-1:0] margin_counts;
  logic [15:0]         margin_frac;

  // Expected output transfers, oldest first.
  result_t pending_picks[$];
  int      err_count;
  bit      idle_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver side: random back-pressure, none while idle_on is clear.
  always @(negedge clk) begin
    m_tready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  // One EMA step; the product is floored (arithmetic shift) like the hardware.
  function automatic logic [AVG_W-1:0] smooth(input logic [AVG_W-1:0] avg,
                                               input logic [SAMPLE_W-1:0] sample);
    longint diff;
    longint prod;
    diff = (longint'(sample) <<< FRAC_BITS) - longint'(avg);
    prod = diff * longint'(gain_q16);
    return AVG_W'(longint'(avg) + (prod >>> FRAC_BITS));
  endfunction

  // Advance the shadow by one accepted item and form the result it produces.
  task automatic pick_brightest(input logic kind, input logic [47:0] lv,
                                output result_t r);
    logic [DIR_W-1:0] best;
    logic [63:0]      best_val;
    logic [63:0]      cur;
    logic [63:0]      lead;
    logic [63:0]      abs_m;
    logic [63:0]      rel_m;
    r = '0;
    if (kind == KIND_SAMPLE) begin
      for (int i = 0; i < LANES; i++) begin
        if (levels_seeded)
          avg_level[i] = smooth(avg_level[i], lv[i*SAMPLE_W +: SAMPLE_W]);
        else
          avg_level[i] = {lv[i*SAMPLE_W +: SAMPLE_W], {FRAC_BITS{1'b0}}};
      end
      levels_seeded = 1'b1;
    end else if (levels_seeded) begin
      // argmax, lowest index keeps a tie
      best     = '0;
      best_val = 64'(avg_level[0]);
      for (int i = 1; i < LANES; i++) begin
        if (64'(avg_level[i]) > best_val) begin
          best_val = 64'(avg_level[i]);
          best     = DIR_W'(i);
        end
      end
      if (!dir_held) begin
        held_dir = best;
        dir_held = 1'b1;
      end else begin
        cur   = 64'(avg_level[held_dir]);
        lead  = best_val - cur;
        abs_m = 64'(margin_counts) << FRAC_BITS;
        rel_m = (best_val * 64'(margin_frac)) >> FRAC_BITS;
        if (lead > ((abs_m > rel_m) ? abs_m : rel_m)) held_dir = best;
      end
    end
    // unseeded evaluate reports all zero
    if (levels_seeded) begin
      r.brightest       = held_dir;
      r.brightest_level = avg_level[held_dir][FRAC_BITS +: LEVEL_W];
      r.is_seeded       = 1'b1;
    end
  endtask

  // Drives one item from a falling edge, returns at the falling edge after
  // its transfer with tvalid still high so back-to-back items need no bubble.
  task automatic send_item(input logic kind, input logic [47:0] lv);
    result_t r;
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= lv;
    do @(posedge clk); while (!s_tready);
    pick_brightest(kind, lv, r);
    pending_picks.push_back(r);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result has come out.
  task automatic wait_drained();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    do begin
      @(negedge clk);
      guard++;
    end while (pending_picks.size() != 0 && guard < DRAIN_GUARD);
    if (pending_picks.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", pending_picks.size()));
      pending_picks.delete();
    end
  endtask

  // Write all three registers one after another while the block is idle.
  task automatic load_settings(input logic [GAIN_W-1:0] gain,
                               input logic [COUNTS_W-1:0] counts,
                               input logic [15:0] frac);
    wait_drained();
    cfg_we        <= 1'b1;
    cfg_index     <= REG_SMOOTHING_GAIN;
    cfg_data      <= CFG_W'(gain);
    gain_q16       = gain;
    @(negedge clk);
    cfg_index     <= REG_HYSTERESIS_COUNTS;
    cfg_data      <= CFG_W'(counts);
    margin_counts  = counts;
    @(negedge clk);
    cfg_index     <= REG_HYSTERESIS_FRACTION;
    cfg_data      <= CFG_W'(frac);
    margin_frac    = frac;
    @(negedge clk);
    cfg_we        <= 1'b0;
  endtask

  // Compare each output transfer against the oldest expectation.
  task automatic check_pick();
    result_t want;
    if (pending_picks.size() == 0) begin
      report_mismatch($sformatf("unexpected result tdata=%h tuser=%b", m_tdata, m_tuser));
    end else begin
      want = pending_picks.pop_front();
      if (m_tdata[DIR_W-1:0] !== want.brightest)
        report_mismatch($sformatf("brightest %0d, expected %0d",
                                  m_tdata[DIR_W-1:0], want.brightest));
      if (m_tdata[DIR_W +: LEVEL_W] !== want.brightest_level)
        report_mismatch($sformatf("brightest_level %0d, expected %0d",
                                  m_tdata[DIR_W +: LEVEL_W], want.brightest_level));
      if (m_tuser !== want.is_seeded)
        report_mismatch($sformatf("is_seeded %b, expected %b", m_tuser, want.is_seeded));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_pick();
  end

  function automatic logic [47:0] pack4(input int n, input int e, input int s, input int w);
    return {12'(w), 12'(s), 12'(e), 12'(n)};
  endfunction

  function automatic logic [47:0] noise48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Mostly a scene with one lit direction, sometimes plain noise or rail values.
  function automatic logic [47:0] scene_levels(input int lit);
    logic [47:0] lv;
    int          mode;
    mode = $urandom_range(99);
    for (int i = 0; i < LANES; i++) begin
      if (mode < 70)
        lv[i*SAMPLE_W +: SAMPLE_W] = (i == lit) ? 12'($urandom_range(4095, 2500))
                                                : 12'($urandom_range(3000, 0));
      else if (mode < 90)
        lv[i*SAMPLE_W +: SAMPLE_W] = 12'($urandom_range(4095, 0));
      else
        lv[i*SAMPLE_W +: SAMPLE_W] = $urandom_range(1) ? 12'hFFF : 12'h000;
    end
    return lv;
  endfunction

  // Evaluate with no data yet: zero result, no choice taken; levels ignored.
  task automatic test_eval_before_seed();
    send_item(KIND_EVAL, pack4(0, 0, 0, 0));
    send_item(KIND_EVAL, pack4(4095, 4095, 4095, 4095));
  endtask

  // First set seeds directly; first evaluate adopts argmax, tie to lower index.
  task automatic test_seed_and_tie();
    send_item(KIND_SAMPLE, pack4(100, 3000, 200, 3000));
    send_item(KIND_EVAL, noise48());
  endtask

  // Rail samples through the default smoothing, the last one all-equal, then an evaluate.
  task automatic test_sample_extremes();
    send_item(KIND_SAMPLE, pack4(0, 0, 0, 0));
    send_item(KIND_SAMPLE, pack4(4095, 4095, 4095, 4095));
    send_item(KIND_SAMPLE, pack4(4095, 0, 4095, 0));
    send_item(KIND_SAMPLE, pack4(4095, 4095, 4095, 4095));
    send_item(KIND_EVAL, noise48());
  endtask

  // Lead just under / over the absolute margin, then the relative margin,
  // then margins so wide nothing moves, then none at all with frozen averages.
  task automatic test_hysteresis_margins();
    load_settings(16'hFFFF, 12'd100, 16'd0);
    send_item(KIND_SAMPLE, pack4(0, 3000, 0, 3090));
    send_item(KIND_EVAL, noise48());
    send_item(KIND_SAMPLE, pack4(0, 3000, 0, 3150));
    send_item(KIND_EVAL, noise48());
    load_settings(16'hFFFF, 12'd0, 16'hFFFF);
    send_item(KIND_SAMPLE, pack4(4095, 0, 0, 0));
    send_item(KIND_EVAL, noise48());
    load_settings(16'hFFFF, 12'd4095, 16'd0);
    send_item(KIND_SAMPLE, pack4(0, 0, 4095, 0));
    send_item(KIND_EVAL, noise48());
    load_settings(16'd0, 12'd0, 16'd0);
    send_item(KIND_SAMPLE, pack4(4095, 4095, 4095, 4095));
    send_item(KIND_EVAL, noise48());
  endtask

  // Random scenes under several register settings, extremes among them.
  task automatic test_random_scenes();
    int                  lit;
    logic [GAIN_W-1:0]   g;
    logic [COUNTS_W-1:0] c;
    logic [15:0]         f;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin g = 16'd9830;  c = 12'd60;   f = 16'd3277;  end
        1: begin g = 16'd0;     c = 12'd0;    f = 16'd0;     end
        2: begin g = 16'hFFFF;  c = 12'hFFF;  f = 16'hFFFF;  end
        3: begin g = 16'hFFFF;  c = 12'd0;    f = 16'd0;     end
        4: begin g = 16'd32768; c = 12'd20;   f = 16'd1000;  end
        5: begin g = 16'd1000;  c = 12'd200;  f = 16'd0;     end
        6: begin
          g = 16'($urandom_range(65535));
          c = 12'($urandom_range(150));
          f = 16'($urandom_range(6000));
        end
        default: begin
          g = 16'($urandom_range(65535));
          c = 12'($urandom_range(4095));
          f = 16'($urandom_range(65535));
        end
      endcase
      load_settings(g, c, f);
      idle_on = (phase != 3);  // one long stretch at full rate on both sides
      lit = $urandom_range(3);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(39) == 0) lit = $urandom_range(3);
        if ($urandom_range(99) < 35)
          send_item(KIND_EVAL, noise48());
        else
          send_item(KIND_SAMPLE, scene_levels(lit));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = KIND_SAMPLE;
    m_tready      = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_SMOOTHING_GAIN;
    cfg_data      = '0;
    idle_on       = 1'b1;
    err_count     = 0;
    // shadow reset, register defaults
    for (int i = 0; i < LANES; i++) avg_level[i] = '0;
    held_dir      = '0;
    dir_held      = 1'b0;
    levels_seeded = 1'b0;
    gain_q16      = 16'd9830;
    margin_counts = 12'd60;
    margin_frac   = 16'd3277;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_eval_before_seed();
    test_seed_and_tie();
    test_sample_extremes();
    test_hysteresis_margins();
    test_random_scenes();

    wait_drained();
    repeat (4) @(negedge clk);  // catch any stray extra result
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
